@@ src/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge out of reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// property must never hold at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("assertion failed");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

@@ src/oate_pkg.sv @@
// shared constants, types and helpers of the ordered array table engine
`default_nettype none
package oate_pkg;

  localparam int DEPTH    = 128;
  localparam int WORD_W   = 32;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int CMP_W    = (CNT_W > 8) ? CNT_W : 8;
  localparam int FAN      = 8;
  localparam int FAN_W    = 3;
  localparam int RED_LVLS = (IDX_W + FAN_W - 1) / FAN_W;
  localparam int PAD      = 1 << (FAN_W * RED_LVLS);

  // offset of the first node of a tree level inside the flat node array
  function automatic int inner_off(input int lvl);
    int acc;
    acc = 0;
    for (int k = 1; k < lvl; k++) begin
      acc += PAD >> (FAN_W * k);
    end
    return acc;
  endfunction

  localparam int INNER_N = inner_off(RED_LVLS + 1);

  // request kinds, the two top codes are unused by the block
  typedef enum logic [2:0] {
    REQ_INSERT,
    REQ_APPEND,
    REQ_DEL_AT,
    REQ_DEL_VAL,
    REQ_READ,
    REQ_FIND,
    REQ_RSVD6,
    REQ_RSVD7
  } req_kind_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL
  } shift_op_e;

  typedef struct packed {
    shift_op_e         op;
    logic [IDX_W-1:0]  pos;
    logic [WORD_W-1:0] word;
  } shift_cmd_t;

  typedef struct packed {
    logic [CMP_W-1:0]  pos;
    logic [CNT_W-1:0]  count;
    logic [WORD_W-1:0] word;
  } probe_t;

  typedef struct packed {
    logic              hit;
    logic [WORD_W-1:0] data;
  } leaf_t;

  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] data;
  } node_t;

  // lowest hit wins, data words are or-ed
  function automatic node_t merge_nodes(input node_t kids [FAN]);
    node_t res;
    res = '0;
    for (int c = FAN - 1; c >= 0; c--) begin
      if (kids[c].hit) begin
        res.hit = 1'b1;
        res.idx = kids[c].idx;
      end
      res.data = res.data | kids[c].data;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ src/oate_cell.sv @@
// one list entry: holds a word, shifts with its neighbors, reports compare results
`default_nettype none
module oate_cell (
  input  wire logic                         clk_i,
  input  wire logic [oate_pkg::IDX_W-1:0]   my_idx_i,
  input  wire oate_pkg::shift_cmd_t         cmd_i,
  input  wire oate_pkg::probe_t             probe_i,
  input  wire logic [oate_pkg::WORD_W-1:0]  left_i,
  input  wire logic [oate_pkg::WORD_W-1:0]  right_i,
  output logic [oate_pkg::WORD_W-1:0]       word_o,
  output oate_pkg::leaf_t                   leaf_o
);

  logic [oate_pkg::WORD_W-1:0] word_q;
  logic                        in_use;
  logic                        at_pos;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      oate_pkg::OP_INS: begin
        if (my_idx_i > cmd_i.pos) begin
          word_q <= left_i;
        end else if (my_idx_i == cmd_i.pos) begin
          word_q <= cmd_i.word;
        end
      end
      oate_pkg::OP_DEL: begin
        if (my_idx_i >= cmd_i.pos) begin
          word_q <= right_i;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_use = oate_pkg::CNT_W'(my_idx_i) < probe_i.count;
  assign at_pos = oate_pkg::CMP_W'(my_idx_i) == probe_i.pos;

  assign word_o      = word_q;
  assign leaf_o.hit  = in_use && (word_q == probe_i.word);
  assign leaf_o.data = (in_use && at_pos) ? word_q : '0;

endmodule
`default_nettype wire

@@ src/oate_reduce.sv @@
// registered 8-ary tree: first matching index and selected word over all cells
`default_nettype none
module oate_reduce (
  input  wire logic              clk_i,
  input  wire oate_pkg::leaf_t   leaves_i [oate_pkg::DEPTH],
  output oate_pkg::node_t        top_o
);

  oate_pkg::node_t leaf_w [oate_pkg::PAD];
  oate_pkg::node_t node_q [oate_pkg::INNER_N];

  for (genvar n = 0; n < oate_pkg::PAD; n++) begin : g_leaf
    if (n < oate_pkg::DEPTH) begin : g_real
      assign leaf_w[n].hit  = leaves_i[n].hit;
      assign leaf_w[n].idx  = oate_pkg::IDX_W'(n);
      assign leaf_w[n].data = leaves_i[n].data;
    end else begin : g_fill
      assign leaf_w[n] = '0;
    end
  end

  for (genvar l = 1; l <= oate_pkg::RED_LVLS; l++) begin : g_lvl
    localparam int NODES = oate_pkg::PAD >> (oate_pkg::FAN_W * l);
    localparam int OFF   = oate_pkg::inner_off(l);
    for (genvar n = 0; n < NODES; n++) begin : g_node
      oate_pkg::node_t kids [oate_pkg::FAN];
      for (genvar c = 0; c < oate_pkg::FAN; c++) begin : g_kid
        if (l == 1) begin : g_from_leaf
          assign kids[c] = leaf_w[oate_pkg::FAN * n + c];
        end else begin : g_from_node
          assign kids[c] = node_q[oate_pkg::inner_off(l - 1) + oate_pkg::FAN * n + c];
        end
      end
      always_ff @(posedge clk_i) begin
        node_q[OFF + n] <= oate_pkg::merge_nodes(kids);
      end
    end
  end

  assign top_o = node_q[oate_pkg::inner_off(oate_pkg::RED_LVLS)];

endmodule
`default_nettype wire

@@ src/ordered_array_table_engine_top.sv @@
// a request beat is accepted only in ST_IDLE, waits in ST_WAIT while the 3-level registered
// compare tree settles (depth 128), then in ST_APPLY loads its result beat into the output register
// once that register is free or draining; no new request is taken until then
// reset: asynchronous active low, clears the fill count, control and output valid
// list words are not reset; entries at or above the fill count are never visible
`default_nettype none
`include "assert_macros.svh"
module ordered_array_table_engine_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request side
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [2:0] req_type
  input  wire logic [2:0]  s_axis_tuser,
  // [7:0] position, [39:8] data_word
  input  wire logic [39:0] s_axis_tdata,
  // result side
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] ok, [32:1] read_data, [39:33] found_position, [47:40] fill_count
  output logic [47:0]      m_axis_tdata
);

  localparam int WORD_W = oate_pkg::WORD_W;
  localparam int IDX_W  = oate_pkg::IDX_W;
  localparam int CNT_W  = oate_pkg::CNT_W;
  localparam int CMP_W  = oate_pkg::CMP_W;
  localparam int DEPTH  = oate_pkg::DEPTH;
  localparam int WAIT_W = $clog2(oate_pkg::RED_LVLS) + 1;
  localparam int FPOS_W = 7;
  localparam int FILL_W = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_APPLY
  } state_e;

  state_e              state_q;
  logic [WAIT_W-1:0]   wait_cnt_q;
  logic [CNT_W-1:0]    count_q;
  logic [CNT_W-1:0]    count_d;
  logic                m_valid_q;
  logic [47:0]         m_data_q;
  logic [47:0]         m_data_d;

  // latched request
  logic [2:0]          kind_q;
  logic [7:0]          pos_q;
  logic [WORD_W-1:0]   word_q;

  logic                accept;
  logic                go;
  logic                not_full;
  logic                ok_w;
  logic [WORD_W-1:0]   rd_w;
  logic [IDX_W-1:0]    fpos_w;
  logic [CMP_W-1:0]    pos_ext;
  logic [CMP_W-1:0]    cnt_ext;
  logic [IDX_W+FPOS_W-1:0] fpos_wide;
  logic [CNT_W+FILL_W-1:0] fill_wide;

  oate_pkg::shift_cmd_t cmd;
  oate_pkg::probe_t     probe;
  oate_pkg::node_t      top_node;
  oate_pkg::leaf_t      leaves [DEPTH];
  logic [WORD_W-1:0]    words  [DEPTH];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // request payload holds while the tree settles and the cells shift
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= s_axis_tuser;
      pos_q  <= s_axis_tdata[7:0];
      word_q <= s_axis_tdata[39:8];
    end
  end

  // every cell sees the same probe: position, word and current fill count
  assign probe.pos   = CMP_W'(pos_q);
  assign probe.count = count_q;
  assign probe.word  = word_q;

  // row of cells, each one passing its word to both neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] left_w;
    logic [WORD_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = words[i];
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = words[i];
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end
    oate_cell u_cell (
      .clk_i    (clk_i),
      .my_idx_i (IDX_W'(i)),
      .cmd_i    (cmd),
      .probe_i  (probe),
      .left_i   (left_w),
      .right_i  (right_w),
      .word_o   (words[i]),
      .leaf_o   (leaves[i])
    );
  end

  // first match and selected word from the registered reduction tree
  oate_reduce u_reduce (
    .clk_i    (clk_i),
    .leaves_i (leaves),
    .top_o    (top_node)
  );

  assign go       = (state_q == ST_APPLY) && (!m_valid_q || m_axis_tready);
  assign pos_ext  = CMP_W'(pos_q);
  assign cnt_ext  = CMP_W'(count_q);
  assign not_full = count_q < CNT_W'(DEPTH);

  // decide outcome, shift command and next fill count
  always_comb begin
    ok_w     = 1'b0;
    rd_w     = '0;
    fpos_w   = '0;
    cmd.op   = oate_pkg::OP_HOLD;
    cmd.pos  = '0;
    cmd.word = word_q;
    count_d  = count_q;
    case (kind_q)
      oate_pkg::REQ_INSERT: begin
        ok_w    = not_full && (pos_ext <= cnt_ext);
        cmd.op  = oate_pkg::OP_INS;
        cmd.pos = IDX_W'(pos_ext);
        count_d = count_q + CNT_W'(1);
      end
      oate_pkg::REQ_APPEND: begin
        ok_w    = not_full;
        cmd.op  = oate_pkg::OP_INS;
        cmd.pos = IDX_W'(cnt_ext);
        count_d = count_q + CNT_W'(1);
      end
      oate_pkg::REQ_DEL_AT: begin
        ok_w    = pos_ext < cnt_ext;
        cmd.op  = oate_pkg::OP_DEL;
        cmd.pos = IDX_W'(pos_ext);
        count_d = count_q - CNT_W'(1);
      end
      oate_pkg::REQ_DEL_VAL: begin
        ok_w    = top_node.hit;
        cmd.op  = oate_pkg::OP_DEL;
        cmd.pos = top_node.idx;
        count_d = count_q - CNT_W'(1);
      end
      oate_pkg::REQ_READ: begin
        ok_w = pos_ext < cnt_ext;
        rd_w = ok_w ? top_node.data : '1;
      end
      oate_pkg::REQ_FIND: begin
        ok_w   = top_node.hit;
        fpos_w = top_node.hit ? top_node.idx : '0;
      end
      default: begin
      end
    endcase
    // refused or stalled requests leave the list untouched
    if (!(go && ok_w)) begin
      cmd.op  = oate_pkg::OP_HOLD;
      count_d = count_q;
    end
  end

  // fields masked to their port widths
  assign fpos_wide = {{FPOS_W{1'b0}}, fpos_w};
  assign fill_wide = {{FILL_W{1'b0}}, count_d};
  assign m_data_d  = {fill_wide[FILL_W-1:0], fpos_wide[FPOS_W-1:0], rd_w, ok_w};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      wait_cnt_q <= '0;
      count_q    <= '0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
    end else begin
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q    <= ST_WAIT;
            wait_cnt_q <= '0;
          end
        end
        ST_WAIT: begin
          wait_cnt_q <= wait_cnt_q + WAIT_W'(1);
          if (wait_cnt_q == WAIT_W'(oate_pkg::RED_LVLS - 1)) begin
            state_q <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (go) begin
            state_q   <= ST_IDLE;
            count_q   <= count_d;
            m_valid_q <= 1'b1;
            m_data_q  <= m_data_d;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // fill count never passes the list size
  `ASSERT_AT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(DEPTH))
  // the fill count only changes when a request is applied
  `ASSERT_AT(a_count_only_apply, clk_i, rst_ni, (state_q != ST_APPLY) |=> $stable(count_q))
  // a single request moves the count by at most one
  `ASSERT_NEVER(a_count_step, clk_i, rst_ni,
    (count_q != $past(count_q)) && (count_q != $past(count_q) + CNT_W'(1)) &&
    (count_q != $past(count_q) - CNT_W'(1)))
  // the settle counter stays within the tree depth
  `ASSERT_NEVER(a_wait_range, clk_i, rst_ni,
    (state_q == ST_WAIT) && (wait_cnt_q >= WAIT_W'(oate_pkg::RED_LVLS)))
  // a result is only loaded when the output register is free or draining
  `ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni,
    go && m_valid_q && !m_axis_tready)

endmodule
`default_nettype wire
